>>> hdl/msb_first_bit_packer_defines.svh
// assertion macros for the bit packer module
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define MFBP_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define MFBP_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> hdl/mfbp_pkg.sv
// types and constants for the msb-first bit packer
`timescale 1ns / 1ps
package mfbp_pkg;

  typedef enum logic [1:0] {
    OP_WRITE        = 2'd0,
    OP_ALIGN_WRITE  = 2'd1,
    OP_ALIGN_VARINT = 2'd2,
    OP_ALIGN        = 2'd3
  } op_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 7;

  typedef struct packed {
    op_t                  operation;
    logic [VALUE_W-1:0]   value;
    logic [WIDTH_W-1:0]   width;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } res_t;

endpackage

>>> hdl/mfbp_out_stage.sv
// output register stage for the packed byte stream
`timescale 1ns / 1ps
module mfbp_out_stage
  import mfbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  output res_t res,
  output logic res_valid,
  input  logic res_stall
);

  // free when empty or when the held transaction leaves this cycle
  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready) begin
      res_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      res <= push_data;
    end
  end

endmodule

>>> hdl/msb_first_bit_packer.sv
// msb-first bit packer with leb128 varint, up to one byte per unstalled cycle
//
//  channel | signals                          | transaction moves
//  --------+----------------------------------+----------------------------
//  item    | item, item_valid, item_stall     | operation, value, width
//  res     | res, res_valid, res_stall        | out_byte, last
//
// an item is taken while idle; the sequencer then emits one byte per cycle
// unless res_stall is high: a padding byte when aligning with bits held,
// then bytes of held and top field bits (or 7-bit varint groups). spare
// field bits that fill no byte merge into the held bits with no byte.
// item_stall is high while the sequencer is busy; a stalled result holds
// the sequencer but not the item side while idle. reset clears held bits.
`timescale 1ns / 1ps
module msb_first_bit_packer
  import mfbp_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  logic  item_valid,
  output logic  item_stall,
  output res_t  res,
  output logic  res_valid,
  input  logic  res_stall
);

`include "msb_first_bit_packer_defines.svh"

  localparam int MAXW = (MAX_FIELD_WIDTH < 32) ? MAX_FIELD_WIDTH : 32;

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_BITS, S_VARINT} state_t;

  state_t             state, state_next;
  op_t                op;
  logic [31:0]        sh, sh_next;
  logic [5:0]         rem, rem_next;
  logic [6:0]         pend, pend_next;
  logic [2:0]         pc, pc_next;

  logic               accept;
  logic [5:0]         wsat;
  logic               adv;
  logic               emit;
  res_t               emit_data;
  logic [3:0]         need;
  logic [7:0]         top8;
  logic [7:0]         merged;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign wsat       = (item.width > 6'(MAXW)) ? 6'(MAXW) : item.width;
  assign need       = 4'd8 - {1'b0, pc};
  assign top8       = sh[31:24];

  mfbp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (emit_data),
    .ready     (adv),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

  always_comb begin
    state_next = state;
    sh_next    = sh;
    rem_next   = rem;
    pend_next  = pend;
    pc_next    = pc;
    emit       = 1'b0;
    emit_data  = '0;
    merged     = ({1'b0, pend} << rem[2:0]) | (top8 >> (4'd8 - {1'b0, rem[2:0]}));
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.operation == OP_ALIGN_VARINT) begin
            sh_next = item.value;
          end else begin
            sh_next = item.value << (6'd32 - wsat);
          end
          rem_next = wsat;
          if (item.operation == OP_WRITE) begin
            state_next = (wsat != 6'd0) ? S_BITS : S_IDLE;
          end else if (pc != 3'd0) begin
            state_next = S_PAD;
          end else if (item.operation == OP_ALIGN_WRITE) begin
            state_next = (wsat != 6'd0) ? S_BITS : S_IDLE;
          end else if (item.operation == OP_ALIGN_VARINT) begin
            state_next = S_VARINT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (adv) begin
          emit               = 1'b1;
          emit_data.out_byte = 8'({1'b0, pend} << need);
          emit_data.last     = !(op == OP_ALIGN_VARINT) &&
                               !(op == OP_ALIGN_WRITE && rem >= 6'd8);
          pend_next          = '0;
          pc_next            = '0;
          if (op == OP_ALIGN_WRITE && rem != 6'd0) begin
            state_next = S_BITS;
          end else if (op == OP_ALIGN_VARINT) begin
            state_next = S_VARINT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_BITS: begin
        if (adv) begin
          if (rem >= {2'b00, need}) begin
            // held bits complete a byte with the top of the field
            emit               = 1'b1;
            emit_data.out_byte = 8'({1'b0, pend} << need) | (top8 >> pc);
            sh_next            = sh << need;
            rem_next           = rem - {2'b00, need};
            emit_data.last     = (rem_next < 6'd8);
            pend_next          = '0;
            pc_next            = '0;
            state_next         = (rem_next == 6'd0) ? S_IDLE : S_BITS;
          end else begin
            // spare bits join the held bits, no byte
            pend_next  = merged[6:0];
            pc_next    = pc + rem[2:0];
            rem_next   = '0;
            state_next = S_IDLE;
          end
        end
      end
      S_VARINT: begin
        if (adv) begin
          emit               = 1'b1;
          emit_data.out_byte = {(|sh[31:7]), sh[6:0]};
          emit_data.last     = ~|sh[31:7];
          sh_next            = sh >> GROUP_W;
          state_next         = (|sh[31:7]) ? S_VARINT : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= '0;
      pc    <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      pc    <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    sh  <= sh_next;
    rem <= rem_next;
    if (accept) begin
      op <= item.operation;
    end
  end

  // held bits above the count stay clear
  `MFBP_ASSERT_NOW(a_pend_clean, clk, rst, 1'b1, (pend >> pc) == 7'd0,
                   "held bits above count not clear")
  // padding only happens with bits held
  `MFBP_ASSERT_NOW(a_pad_nonzero, clk, rst, state == S_PAD, pc != 3'd0,
                   "padding with no held bits")
  // varint groups are always byte aligned
  `MFBP_ASSERT_NOW(a_varint_aligned, clk, rst, state == S_VARINT, pc == 3'd0,
                   "varint group not aligned")
  // after a byte marked last only a merge of spare bits may remain
  `MFBP_ASSERT_NEXT(a_last_final, clk, rst, emit && emit_data.last,
                    state == S_IDLE || rem < 6'd8, "byte pending after last byte")

endmodule
